// ===== sv/gtdl_pkg.sv =====
package gtdl_pkg;

  // input item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_SCALE_X  = 3'd3;
  localparam logic [2:0] REG_SCALE_Y  = 3'd4;
  localparam logic [2:0] REG_SCALE_Z  = 3'd5;

  localparam logic [31:0] ORIGIN_RESET = 32'h0000_0000;
  localparam logic [31:0] SCALE_RESET  = 32'h0010_0000;

  // one half in Q32.32
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

  localparam int GRID_DEPTH = 4096;
  localparam int ADDR_W     = 12;
  localparam int IDX_W      = 8;
  localparam int DENS_W     = 16;

  // per-axis mapping result
  typedef struct packed {
    logic             outside;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [15:0]      t;
  } axis_t;

endpackage

// ===== sv/gtdl_axis.sv =====
module gtdl_axis #(
  parameter int SIZE = 16
) (
  input  logic               clk,
  input  logic signed [31:0] point,
  input  logic signed [31:0] origin,
  input  logic        [31:0] scale,
  output gtdl_pkg::axis_t    axis
);

  localparam logic [63:0] LIMIT = 64'(SIZE) << 32;
  localparam logic [8:0]  TOP   = 9'(SIZE - 1);

  logic signed [32:0] diff;
  logic        [63:0] u;
  logic               neg_out;
  logic        [63:0] u_lo;
  logic        [63:0] u_hi;
  logic        [8:0]  h;
  gtdl_pkg::axis_t    axis_next;

  // stage 1: offset from the box minimum
  always_ff @(posedge clk) begin
    diff <= 33'(point) - 33'(origin);
  end

  // stage 2: scale into cell units, 32x32 product
  always_ff @(posedge clk) begin
    neg_out <= diff[32] && (scale != 32'd0);
    u       <= diff[32] ? 64'd0 : 64'(diff[31:0]) * 64'(scale);
  end

  // stage 3: bounds, corner indexes, fraction
  always_comb begin
    u_lo = u - gtdl_pkg::HALF_Q32;
    u_hi = u + gtdl_pkg::HALF_Q32;
    h    = u_hi[40:32];
    axis_next.outside = neg_out || (u > LIMIT);
    if (u < gtdl_pkg::HALF_Q32) begin
      axis_next.lo = '0;
      axis_next.t  = '0;
    end else begin
      axis_next.lo = u_lo[39:32];
      axis_next.t  = u_lo[31:16];
    end
    axis_next.hi = (h > TOP) ? TOP[7:0] : h[7:0];
  end

  always_ff @(posedge clk) begin
    axis <= axis_next;
  end

endmodule

// ===== sv/grid_trilinear_density_lookup.sv =====
// Trilinear density lookup: start with func=0 loads cell_value at cell_index;
// start with func=1 queries the density at point_x/y/z (signed Q16.16). busy is
// never raised, so one item can be issued every cycle. Each query gives one
// result beat, marked by done; the receiver cannot stall and must take it in
// that cycle. Loads give no beat. Points outside the box read density 0 with
// outside set. The pipe runs offset, 32x32 scale multiply, axis mapping, grid
// read, then one stage per interpolation axis. The grid is held in four
// identical copies with two read ports each so all eight corners are read in
// the same cycle; loads write all copies at the same pipe stage as query
// reads, so a query sees every load issued before it and none issued after.
// Cells never loaded read as garbage. Configuration is written through
// cfg_valid/cfg_ready (always ready) and must only change while no query is
// in flight.
module grid_trilinear_density_lookup #(
  parameter int SIZE_X = 16,
  parameter int SIZE_Y = 16,
  parameter int SIZE_Z = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               func,
  input  logic        [11:0] cell_index,
  input  logic        [15:0] cell_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               done,
  output logic        [15:0] density,
  output logic               outside,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int AW = gtdl_pkg::ADDR_W;
  localparam logic [AW-1:0] STRIDE_X = AW'((SIZE_Y * SIZE_Z) % gtdl_pkg::GRID_DEPTH);
  localparam logic [AW-1:0] STRIDE_Y = AW'(SIZE_Z % gtdl_pkg::GRID_DEPTH);

  // interpolation, floor of a*(1-t) + b*t
  function automatic logic [15:0] lerp16(input logic [15:0] t, input logic [15:0] a,
                                         input logic [15:0] b);
    logic [16:0] wt;
    logic [33:0] s;
    wt = 17'h10000 - {1'b0, t};
    s  = 34'(a) * 34'(wt) + 34'(b) * 34'(t);
    return s[31:16];
  endfunction

  // configuration
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic        [31:0] scale_x, scale_y, scale_z;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= gtdl_pkg::ORIGIN_RESET;
      origin_y <= gtdl_pkg::ORIGIN_RESET;
      origin_z <= gtdl_pkg::ORIGIN_RESET;
      scale_x  <= gtdl_pkg::SCALE_RESET;
      scale_y  <= gtdl_pkg::SCALE_RESET;
      scale_z  <= gtdl_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gtdl_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        gtdl_pkg::REG_ORIGIN_Y: origin_y <= cfg_data;
        gtdl_pkg::REG_ORIGIN_Z: origin_z <= cfg_data;
        gtdl_pkg::REG_SCALE_X:  scale_x  <= cfg_data;
        gtdl_pkg::REG_SCALE_Y:  scale_y  <= cfg_data;
        gtdl_pkg::REG_SCALE_Z:  scale_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-axis mapping: offset, scale multiply and bounds stages
  gtdl_pkg::axis_t ax, ay, az;

  gtdl_axis #(.SIZE(SIZE_X)) u_axis_x (
    .clk(clk), .point(point_x), .origin(origin_x), .scale(scale_x), .axis(ax));
  gtdl_axis #(.SIZE(SIZE_Y)) u_axis_y (
    .clk(clk), .point(point_y), .origin(origin_y), .scale(scale_y), .axis(ay));
  gtdl_axis #(.SIZE(SIZE_Z)) u_axis_z (
    .clk(clk), .point(point_z), .origin(origin_z), .scale(scale_z), .axis(az));

  // control pipe: stage 1..3 beside the axis units
  logic [2:0]    vld_q, fn_q;
  logic [AW-1:0] widx1, widx2, widx3;
  logic [15:0]   wval1, wval2, wval3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start && !busy};
    end
  end

  always_ff @(posedge clk) begin
    fn_q  <= {fn_q[1:0], func};
    widx1 <= cell_index;
    widx2 <= widx1;
    widx3 <= widx2;
    wval1 <= cell_value;
    wval2 <= wval1;
    wval3 <= wval2;
  end

  // corner addresses, bit 0 picks x high, bit 1 y high, bit 2 z high
  logic [AW-1:0] raddr [8];
  logic [AW-1:0] xo [2];
  logic [AW-1:0] yo [2];
  logic [AW-1:0] zo [2];

  always_comb begin
    xo[0] = AW'({4'b0, ax.lo} * STRIDE_X);
    xo[1] = AW'({4'b0, ax.hi} * STRIDE_X);
    yo[0] = AW'({4'b0, ay.lo} * STRIDE_Y);
    yo[1] = AW'({4'b0, ay.hi} * STRIDE_Y);
    zo[0] = {4'b0, az.lo};
    zo[1] = {4'b0, az.hi};
    for (int k = 0; k < 8; k++) begin
      raddr[k] = xo[k[0]] + yo[k[1]] + zo[k[2]];
    end
  end

  // grid store: four copies, one write and two reads each
  logic [15:0] grid [4][gtdl_pkg::GRID_DEPTH];
  logic [15:0] rdata [8];
  logic        load3, query3;

  assign load3  = vld_q[2] && (fn_q[2] == gtdl_pkg::FUNC_LOAD);
  assign query3 = vld_q[2] && (fn_q[2] == gtdl_pkg::FUNC_QUERY);

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      if (load3) begin
        grid[c][widx3] <= wval3;
      end
      rdata[2*c]   <= grid[c][raddr[2*c]];
      rdata[2*c+1] <= grid[c][raddr[2*c+1]];
    end
  end

  // stage 4..6 control and fractions
  logic        v4, v5, v6;
  logic        out4, out5, out6;
  logic [15:0] tx4, ty4, tz4, ty5, tz5, tz6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4   <= 1'b0;
      v5   <= 1'b0;
      v6   <= 1'b0;
      done <= 1'b0;
    end else begin
      v4   <= query3;
      v5   <= v4;
      v6   <= v5;
      done <= v6;
    end
  end

  always_ff @(posedge clk) begin
    out4 <= ax.outside || ay.outside || az.outside;
    tx4  <= ax.t;
    ty4  <= ay.t;
    tz4  <= az.t;
    out5 <= out4;
    ty5  <= ty4;
    tz5  <= tz4;
    out6 <= out5;
    tz6  <= tz5;
  end

  // interpolation: x, then y, then z
  logic [15:0] d00, d10, d01, d11, d0, d1;

  always_ff @(posedge clk) begin
    d00 <= lerp16(tx4, rdata[0], rdata[1]);
    d10 <= lerp16(tx4, rdata[2], rdata[3]);
    d01 <= lerp16(tx4, rdata[4], rdata[5]);
    d11 <= lerp16(tx4, rdata[6], rdata[7]);
    d0  <= lerp16(ty5, d00, d10);
    d1  <= lerp16(ty5, d01, d11);
    density <= out6 ? 16'd0 : lerp16(tz6, d0, d1);
    outside <= out6;
  end

endmodule
